// ----- rtl/cbp_pkg.sv -----
// Shared types and constants for the cubic Bezier point core.
// No dependencies; every rtl file imports this package.
package cbp_pkg;

	localparam int COORD_W   = 16;
	localparam int FRAC_BITS = 4;
	localparam int IDX_W     = 14;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SQ_W      = 2 * DIFF_W;
	localparam int ROOT_W    = DIFF_W;
	localparam int REM_W     = ROOT_W + 3;
	localparam int T_FRAC    = 16;
	localparam int T_W       = T_FRAC + 1;
	localparam int WGT_FRAC  = 2 * T_FRAC;
	localparam int WGT_W     = WGT_FRAC + 1;
	localparam int PROD_W    = WGT_W + 1 + COORD_W;
	localparam int ACC_W     = PROD_W + 2;

	localparam logic [IDX_W-1:0] MIN_STEPS_RESET = IDX_W'(100);
	localparam logic [T_W-1:0]   T_ONE           = T_W'(1) << T_FRAC;

	typedef struct packed {
		logic signed [COORD_W-1:0] p0_x;
		logic signed [COORD_W-1:0] p0_y;
		logic signed [COORD_W-1:0] p1_x;
		logic signed [COORD_W-1:0] p1_y;
		logic signed [COORD_W-1:0] p2_x;
		logic signed [COORD_W-1:0] p2_y;
		logic signed [COORD_W-1:0] p3_x;
		logic signed [COORD_W-1:0] p3_y;
		logic [IDX_W-1:0]          sample_index;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [IDX_W-1:0]          step_count;
		logic                      is_last;
	} out_item_t;

endpackage

// ----- rtl/cbp_step_div.sv -----
// Step count and curve parameter pipeline: bit-serial square root stages,
// step count stage, then restoring divider stages. Depends on cbp_pkg.
module cbp_step_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_valid,
	input  logic [cbp_pkg::SQ_W-1:0]    sq_sum,
	input  cbp_pkg::in_item_t           in_item,
	input  logic [cbp_pkg::IDX_W-1:0]   min_steps,
	output logic                        out_valid,
	output cbp_pkg::in_item_t           out_item,
	output logic [cbp_pkg::IDX_W-1:0]   steps,
	output logic [cbp_pkg::T_W-1:0]     t,
	output logic                        last
);
	import cbp_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_step_t;

	typedef struct packed {
		logic [IDX_W-1:0]  rem;
		logic [T_FRAC-1:0] q;
	} dv_step_t;

	function automatic sq_step_t sqrt_step(logic [REM_W-1:0] rem, logic [ROOT_W-1:0] root,
			logic [1:0] bits);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] trial;
		sq_step_t         o;
		r     = {rem[REM_W-3:0], bits};
		trial = {1'b0, root, 2'b01};
		if (r >= trial) begin
			o.rem  = r - trial;
			o.root = {root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic dv_step_t div_step(logic [IDX_W-1:0] rem, logic [T_FRAC-1:0] q,
			logic [IDX_W-1:0] d);
		logic [IDX_W:0] r;
		dv_step_t       o;
		r = {rem, 1'b0};
		if (r >= {1'b0, d}) begin
			o.rem = IDX_W'(r - {1'b0, d});
			o.q   = {q[T_FRAC-2:0], 1'b1};
		end else begin
			o.rem = r[IDX_W-1:0];
			o.q   = {q[T_FRAC-2:0], 1'b0};
		end
		return o;
	endfunction

	// square root stages, index 0 is the input
	logic [SQ_W-1:0]   n_s    [0:ROOT_W];
	logic [REM_W-1:0]  srem_s [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	in_item_t          sitm_s [0:ROOT_W];
	logic              svld_s [0:ROOT_W];

	// step count stage
	logic [IDX_W-1:0]  steps_st;
	logic              last_st;
	logic              vld_st;
	in_item_t          itm_st;

	// divider stages, index 0 is the step count stage
	logic [IDX_W-1:0]  drem_s  [0:T_FRAC];
	logic [T_FRAC-1:0] q_s     [0:T_FRAC];
	logic [IDX_W-1:0]  dsteps_s[0:T_FRAC];
	logic              dlast_s [0:T_FRAC];
	in_item_t          ditm_s  [0:T_FRAC];
	logic              dvld_s  [0:T_FRAC];

	logic [ROOT_W-1:0] px;
	logic [ROOT_W+1:0] tri_px;
	logic [ROOT_W:0]   raw_steps;
	logic [IDX_W-1:0]  sat_steps;
	logic [IDX_W-1:0]  new_steps;

	assign n_s[0]    = sq_sum;
	assign srem_s[0] = '0;
	assign root_s[0] = '0;
	assign sitm_s[0] = in_item;
	assign svld_s[0] = in_valid;

	// pixel distance times 1.5, saturated to the index range, floored at min_steps and one
	always_comb begin
		px        = root_s[ROOT_W] >> FRAC_BITS;
		tri_px    = {px, 1'b0} + {2'b00, px};
		raw_steps = tri_px[ROOT_W+1:1];
		if (raw_steps > (ROOT_W+1)'({IDX_W{1'b1}})) begin
			sat_steps = {IDX_W{1'b1}};
		end else begin
			sat_steps = raw_steps[IDX_W-1:0];
		end
		new_steps = (sat_steps < min_steps) ? min_steps : sat_steps;
		if (new_steps == '0) begin
			new_steps = IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 1; k <= ROOT_W; k++) begin
				{srem_s[k], root_s[k]} <= sqrt_step(srem_s[k-1], root_s[k-1],
					n_s[k-1][SQ_W-1:SQ_W-2]);
				n_s[k]    <= n_s[k-1] << 2;
				sitm_s[k] <= sitm_s[k-1];
			end
			steps_st <= new_steps;
			last_st  <= (sitm_s[ROOT_W].sample_index >= new_steps);
			itm_st   <= sitm_s[ROOT_W];
			for (int k = 1; k <= T_FRAC; k++) begin
				{drem_s[k], q_s[k]} <= div_step(drem_s[k-1], q_s[k-1], dsteps_s[k-1]);
				dsteps_s[k] <= dsteps_s[k-1];
				dlast_s[k]  <= dlast_s[k-1];
				ditm_s[k]   <= ditm_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ROOT_W; k++) begin
				svld_s[k] <= 1'b0;
			end
			vld_st <= 1'b0;
			for (int k = 1; k <= T_FRAC; k++) begin
				dvld_s[k] <= 1'b0;
			end
		end else if (advance) begin
			for (int k = 1; k <= ROOT_W; k++) begin
				svld_s[k] <= svld_s[k-1];
			end
			vld_st <= svld_s[ROOT_W];
			for (int k = 1; k <= T_FRAC; k++) begin
				dvld_s[k] <= dvld_s[k-1];
			end
		end
	end

	// index below the step count starts the remainder; past the end it is dropped
	assign drem_s[0]   = last_st ? '0 : itm_st.sample_index;
	assign q_s[0]      = '0;
	assign dsteps_s[0] = steps_st;
	assign dlast_s[0]  = last_st;
	assign ditm_s[0]   = itm_st;
	assign dvld_s[0]   = vld_st;

	assign out_valid = dvld_s[T_FRAC];
	assign out_item  = ditm_s[T_FRAC];
	assign steps     = dsteps_s[T_FRAC];
	assign last      = dlast_s[T_FRAC];
	assign t         = dlast_s[T_FRAC] ? T_ONE : {1'b0, q_s[T_FRAC]};

	a_steps_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_st |-> steps_st != '0)
		else $error("step count of zero");
	a_steps_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_st |-> (steps_st >= min_steps || min_steps == '0))
		else $error("step count below minimum");
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> t[T_W-1] == 1'b0)
		else $error("curve parameter out of range");

endmodule

// ----- rtl/cubic_bezier_point_core.sv -----
// Top level of the cubic Bezier point core: distance front end, step/divider
// pipeline, Bernstein weight and blend stages. Depends on cbp_pkg, cbp_step_div.
// Order: front end, square root, step count, divider, weight stages a to d, result.
// Throughput: one item per cycle; every stage is a register row, one global enable.
// The square root takes one root bit per stage and the divider one quotient bit per stage.
// Stall: the whole pipe holds while a result waits and result_stall is high.
// Reset: async active low clears all valid bits and sets min_steps to 100.
module cubic_bezier_point_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  cbp_pkg::in_item_t         item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output cbp_pkg::out_item_t        result,
	input  logic                      cfg_we,
	input  logic [cbp_pkg::IDX_W-1:0] cfg_wdata
);
	import cbp_pkg::*;

	logic                      advance;
	logic [IDX_W-1:0]          min_steps_q;

	// front end: differences, squares, sum
	logic                      vld_s1, vld_s2, vld_s3;
	in_item_t                  itm_s1, itm_s2, itm_s3;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;
	logic [SQ_W-2:0]           sqx_s2, sqy_s2;
	logic [SQ_W-1:0]           sum_s3;

	// step/divider output
	logic                      dv_valid;
	in_item_t                  dv_item;
	logic [IDX_W-1:0]          dv_steps;
	logic [T_W-1:0]            dv_t;
	logic                      dv_last;

	// weight and blend stages
	logic                      vld_a, vld_b, vld_c, vld_d;
	in_item_t                  itm_a, itm_b, itm_c;
	logic [IDX_W-1:0]          stp_a, stp_b, stp_c, stp_d;
	logic                      lst_a, lst_b, lst_c, lst_d;
	logic [T_W-1:0]            t_a;
	logic [2*T_W-1:0]          tt_a, st_a, ss_a;
	logic [3*T_W-1:0]          c3_b, m2_b, m1_b;
	logic [WGT_W-1:0]          w0_c, w1_c, w2_c, w3_c;
	logic signed [PROD_W-1:0]  prx_d [0:3];
	logic signed [PROD_W-1:0]  pry_d [0:3];

	logic [3*T_W+1:0]          c2_x3, c1_x3;
	logic [WGT_W:0]            w0_full;
	logic signed [ACC_W-1:0]   accx, accy;
	logic signed [COORD_W-1:0] ptx [0:3];
	logic signed [COORD_W-1:0] pty [0:3];
	logic [WGT_W-1:0]          wgt [0:3];

	// advance the whole pipe unless a finished result is held back
	assign advance    = !(result_valid && result_stall);
	assign item_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_steps_q <= MIN_STEPS_RESET;
		end else if (cfg_we) begin
			min_steps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dx_s1  <= DIFF_W'(item.p3_x) - DIFF_W'(item.p0_x);
			dy_s1  <= DIFF_W'(item.p3_y) - DIFF_W'(item.p0_y);
			itm_s1 <= item;
			sqx_s2 <= (SQ_W-1)'(dx_s1 * dx_s1);
			sqy_s2 <= (SQ_W-1)'(dy_s1 * dy_s1);
			itm_s2 <= itm_s1;
			sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			itm_s3 <= itm_s2;
		end
	end

	cbp_step_div u_step_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (vld_s3),
		.sq_sum    (sum_s3),
		.in_item   (itm_s3),
		.min_steps (min_steps_q),
		.out_valid (dv_valid),
		.out_item  (dv_item),
		.steps     (dv_steps),
		.t         (dv_t),
		.last      (dv_last)
	);

	// triple the middle weights, drop 16 fraction bits, close the sum to one
	always_comb begin
		c2_x3   = {m2_b, 1'b0} + {1'b0, m2_b};
		c1_x3   = {m1_b, 1'b0} + {1'b0, m1_b};
		w0_full = (WGT_W+1)'(1) << WGT_FRAC;
		w0_full = w0_full - (WGT_W+1)'(c1_x3 >> T_FRAC) - (WGT_W+1)'(c2_x3 >> T_FRAC)
			- (WGT_W+1)'(c3_b >> T_FRAC);
	end

	assign ptx[0] = itm_c.p0_x;
	assign ptx[1] = itm_c.p1_x;
	assign ptx[2] = itm_c.p2_x;
	assign ptx[3] = itm_c.p3_x;
	assign pty[0] = itm_c.p0_y;
	assign pty[1] = itm_c.p1_y;
	assign pty[2] = itm_c.p2_y;
	assign pty[3] = itm_c.p3_y;
	assign wgt[0] = w0_c;
	assign wgt[1] = w1_c;
	assign wgt[2] = w2_c;
	assign wgt[3] = w3_c;

	always_ff @(posedge clk) begin
		if (advance) begin
			// stage a: t, s and their pairwise products
			t_a   <= dv_t;
			tt_a  <= dv_t * dv_t;
			st_a  <= (T_ONE - dv_t) * dv_t;
			ss_a  <= (T_ONE - dv_t) * (T_ONE - dv_t);
			itm_a <= dv_item;
			stp_a <= dv_steps;
			lst_a <= dv_last;
			// stage b: cubic terms
			c3_b  <= (3*T_W)'(tt_a * t_a);
			m2_b  <= (3*T_W)'(st_a * t_a);
			m1_b  <= (3*T_W)'(ss_a * t_a);
			itm_b <= itm_a;
			stp_b <= stp_a;
			lst_b <= lst_a;
			// stage c: 32-fraction-bit weights
			w3_c  <= WGT_W'(c3_b >> T_FRAC);
			w2_c  <= WGT_W'(c2_x3 >> T_FRAC);
			w1_c  <= WGT_W'(c1_x3 >> T_FRAC);
			w0_c  <= w0_full[WGT_W-1:0];
			itm_c <= itm_b;
			stp_c <= stp_b;
			lst_c <= lst_b;
			// stage d: weighted coordinates
			for (int i = 0; i < 4; i++) begin
				prx_d[i] <= $signed({1'b0, wgt[i]}) * ptx[i];
				pry_d[i] <= $signed({1'b0, wgt[i]}) * pty[i];
			end
			stp_d <= stp_c;
			lst_d <= lst_c;
		end
	end

	// sum and round to nearest, ties toward plus infinity
	always_comb begin
		accx = ACC_W'(prx_d[0]) + ACC_W'(prx_d[1]) + ACC_W'(prx_d[2]) + ACC_W'(prx_d[3])
			+ (ACC_W'(1) <<< (WGT_FRAC - 1));
		accy = ACC_W'(pry_d[0]) + ACC_W'(pry_d[1]) + ACC_W'(pry_d[2]) + ACC_W'(pry_d[3])
			+ (ACC_W'(1) <<< (WGT_FRAC - 1));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.point_x    <= accx[WGT_FRAC+COORD_W-1:WGT_FRAC];
			result.point_y    <= accy[WGT_FRAC+COORD_W-1:WGT_FRAC];
			result.step_count <= stp_d;
			result.is_last    <= lst_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_a        <= 1'b0;
			vld_b        <= 1'b0;
			vld_c        <= 1'b0;
			vld_d        <= 1'b0;
			result_valid <= 1'b0;
		end else if (advance) begin
			vld_s1       <= item_valid;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_a        <= dv_valid;
			vld_b        <= vld_a;
			vld_c        <= vld_b;
			vld_d        <= vld_c;
			result_valid <= vld_d;
		end
	end

	a_wgt_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c |-> (WGT_W+2)'(w0_c) + (WGT_W+2)'(w1_c) + (WGT_W+2)'(w2_c) + (WGT_W+2)'(w3_c)
			== (WGT_W+2)'(1) << WGT_FRAC)
		else $error("weights do not sum to one");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_c && lst_c) |-> (w3_c == WGT_W'(1) << WGT_FRAC))
		else $error("last sample not at curve end");
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(vld_d))
		else $error("result without pipeline item");

endmodule
